@@ sv/assert_macros.svh @@
// Assertion macros shared by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mih_pkg.sv @@
// Shared types and constants of the multichannel image histogram.
package mih_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int CH_BITS      = 2;
  localparam int BIN_BITS     = 12;
  localparam int COUNT_BITS   = 25;
  localparam int POS_BITS     = 24;
  localparam int PIX_BITS     = 16;
  localparam int DEPTH_BITS   = 4;
  localparam int CHCNT_BITS   = 3;
  localparam int DIM_BITS     = 13;
  localparam int PLANE_BITS   = 25;
  localparam int CFG_BITS     = 13;
  localparam int ADDR_BITS    = CH_BITS + BIN_BITS;
  localparam int STORE_DEPTH  = 1 << ADDR_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [DIM_BITS-1:0]   DIM_MAX   = 13'd4096;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = 4'd12;
  localparam logic [CHCNT_BITS-1:0] CH_MAX    = 3'd4;

  localparam logic [DEPTH_BITS-1:0] RST_BIT_DEPTH     = 4'd8;
  localparam logic [CHCNT_BITS-1:0] RST_CHANNEL_COUNT = 3'd1;
  localparam logic [DIM_BITS-1:0]   RST_FRAME_WIDTH   = 13'd640;
  localparam logic [DIM_BITS-1:0]   RST_FRAME_HEIGHT  = 13'd480;

  typedef enum logic [1:0] {
    REG_BIT_DEPTH     = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_FRAME_WIDTH   = 2'd2,
    REG_FRAME_HEIGHT  = 2'd3
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;   // capture the request
    logic sweep;   // write zero at the sweep address, advance it
    logic commit;  // finish the request: update bin, position, result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic first_pixel; // incoming request is the first pixel of a frame
    logic sweep_last;  // sweep address is at the last entry
  } ctrl_stat_t;

endpackage

@@ sv/mih_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mih_ctrl.sv @@
// Control state machine of the histogram: sweep, fetch and commit sequencing.
module mih_ctrl
  import mih_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,  // clear sweep after reset
    S_IDLE  = 5'b00010,
    S_CLEAR = 5'b00100,  // clear sweep before the first pixel of a frame
    S_FETCH = 5'b01000,  // bin address on the RAM read port
    S_WRITE = 5'b10000   // read data back, update and report
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = (state == S_IDLE) && start;
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = stat.first_pixel ? S_CLEAR : S_FETCH;
      end
      S_CLEAR: begin
        if (stat.sweep_last) state_next = S_FETCH;
      end
      S_FETCH: state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.latch  = accept;
    cmd.sweep  = (state == S_INIT) || (state == S_CLEAR);
    cmd.commit = (state == S_WRITE);
  end

endmodule

@@ sv/mih_datapath.sv @@
// Histogram datapath: config registers, position tracking, bin RAM, result register.
module mih_datapath
  import mih_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  mode,
  input  logic [PIX_BITS-1:0]   pixel_value,
  input  logic [CH_BITS-1:0]    read_channel,
  input  logic [BIN_BITS-1:0]   read_bin,
  input  ctrl_cmd_t             cmd,
  output ctrl_stat_t            stat,
  output logic                  result_strobe,
  output logic [COUNT_BITS-1:0] bin_count,
  output logic                  frame_done,
  output logic                  out_of_range
);

  // config
  logic [DEPTH_BITS-1:0] bit_depth;
  logic [CHCNT_BITS-1:0] channel_count;
  logic [DIM_BITS-1:0]   frame_width;
  logic [DIM_BITS-1:0]   frame_height;
  logic [DEPTH_BITS-1:0] depth_used;
  logic [CHCNT_BITS-1:0] ch_used;
  logic [DIM_BITS-1:0]   width_used;
  logic [DIM_BITS-1:0]   height_used;
  logic [PLANE_BITS-1:0] plane_size;

  // position
  logic [POS_BITS-1:0]   pos;
  logic [CH_BITS-1:0]    chan;
  logic [PLANE_BITS-1:0] pos_inc;
  logic [CHCNT_BITS-1:0] chan_inc;

  // held request
  logic                  it_mode;
  logic [PIX_BITS-1:0]   it_pix;
  logic [CH_BITS-1:0]    it_rch;
  logic [BIN_BITS-1:0]   it_rbin;

  // bin RAM
  logic [ADDR_BITS-1:0]  sweep_addr;
  logic [ADDR_BITS-1:0]  bin_addr;
  logic [ADDR_BITS-1:0]  waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] rdata_inc;
  logic                  we;
  logic                  pix_oor;
  logic                  read_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_depth     <= RST_BIT_DEPTH;
      channel_count <= RST_CHANNEL_COUNT;
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIT_DEPTH:     bit_depth     <= cfg_data[DEPTH_BITS-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHCNT_BITS-1:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // saturate registers to their usable ranges
  always_comb begin
    depth_used  = (bit_depth == '0) ? DEPTH_BITS'(1) :
                  (bit_depth > DEPTH_MAX) ? DEPTH_MAX : bit_depth;
    ch_used     = (channel_count == '0) ? CHCNT_BITS'(1) :
                  (channel_count > CH_MAX) ? CH_MAX : channel_count;
    width_used  = (frame_width == '0) ? DIM_BITS'(1) :
                  (frame_width > DIM_MAX) ? DIM_MAX : frame_width;
    height_used = (frame_height == '0) ? DIM_BITS'(1) :
                  (frame_height > DIM_MAX) ? DIM_MAX : frame_height;
  end

  // plane size registered; user must move config only when idle, unenforced by block
  always_ff @(posedge clk) begin
    plane_size <= PLANE_BITS'(width_used) * PLANE_BITS'(height_used);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_mode <= mode;
      it_pix  <= pixel_value;
      it_rch  <= read_channel;
      it_rbin <= read_bin;
    end
  end

  assign stat.first_pixel = !mode && (pos == '0) && (chan == '0);
  assign stat.sweep_last  = &sweep_addr;

  // wraps back to zero after the last entry, ready for the next sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_addr + ADDR_BITS'(1);
    end
  end

  assign bin_addr  = it_mode ? {it_rch, it_rbin} : {chan, it_pix[BIN_BITS-1:0]};
  assign pix_oor   = (it_pix >> depth_used) != '0;
  assign read_ok   = ({1'b0, it_rch} < ch_used) && ((it_rbin >> depth_used) == '0);
  assign rdata_inc = (rdata == COUNT_MAX) ? rdata : rdata + COUNT_BITS'(1);

  always_comb begin
    if (cmd.sweep) begin
      we    = 1'b1;
      waddr = sweep_addr;
      wdata = '0;
    end else begin
      we    = cmd.commit && !it_mode && !pix_oor;
      waddr = bin_addr;
      wdata = rdata_inc;
    end
  end

  mih_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (bin_addr),
    .rdata (rdata)
  );

  assign pos_inc  = {1'b0, pos} + PLANE_BITS'(1);
  assign chan_inc = {1'b0, chan} + CHCNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      chan <= '0;
    end else if (cmd.commit && !it_mode) begin
      if (pos_inc >= plane_size) begin
        pos <= '0;
        if (chan_inc >= ch_used) begin
          chan <= '0;
        end else begin
          chan <= chan_inc[CH_BITS-1:0];
        end
      end else begin
        pos <= pos_inc[POS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      bin_count    <= (it_mode && read_ok) ? rdata : '0;
      frame_done   <= !it_mode && (pos_inc >= plane_size) && (chan_inc >= ch_used);
      out_of_range <= !it_mode && pix_oor;
    end
  end

endmodule

@@ sv/multichannel_image_histogram_top.sv @@
// Top level of the multichannel image histogram.
//
// Counts one histogram per channel plane of a planar frame (all of plane 0,
// then plane 1, ...); the block tracks pixel and plane position itself.
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with result_strobe high, and the
// receiver cannot hold it off. A pixel request (mode 0) increments the bin
// of its value in the current plane, saturating at 2^25-1; values at or
// above 2^bit_depth are flagged out_of_range and not counted but still take
// their slot in the frame; frame_done marks the last pixel of the last
// plane. A read request (mode 1) returns one bin count, or zero when the
// channel or bin lies outside the configured range.
// Sequence: after accept a request runs the RAM read, then the
// read-modify-write into the single-port-per-side bin RAM, then the result
// register; busy stays high until then, so a new request is taken only
// once the last one is through. The first pixel of each frame first runs
// a clear sweep over all 16384 bin entries, one per cycle, before its RAM
// read. After reset the same sweep runs before busy drops.
// Config writes are taken at any time but must only be issued while idle.
`include "assert_macros.svh"

module multichannel_image_histogram_top
  import mih_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  // request
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [PIX_BITS-1:0]   pixel_value,
  input  logic [CH_BITS-1:0]    read_channel,
  input  logic [BIN_BITS-1:0]   read_bin,
  // result
  output logic                  result_strobe,
  output logic [COUNT_BITS-1:0] bin_count,
  output logic                  frame_done,
  output logic                  out_of_range
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  mih_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mih_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .pixel_value   (pixel_value),
    .read_channel  (read_channel),
    .read_bin      (read_bin),
    .cmd           (cmd),
    .stat          (stat),
    .result_strobe (result_strobe),
    .bin_count     (bin_count),
    .frame_done    (frame_done),
    .out_of_range  (out_of_range)
  );

  // an accepted request keeps the block busy while it is worked on
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")

  // a result only follows work in progress
  `ASSERT_IMPLIES(a_result_after_busy, clk, rst, result_strobe, $past(busy), "result without a request")

  // one result per request, never on consecutive cycles
  `ASSERT_NEXT(a_single_result, clk, rst, result_strobe, !result_strobe, "result repeated")

endmodule
